// ----- sv/tst_pkg.sv -----
`default_nettype none

package tst_pkg;

  // Input operation codes
  localparam logic [1:0] OP_MOVE = 2'd0;
  localparam logic [1:0] OP_DOWN = 2'd1;
  localparam logic [1:0] OP_UP   = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Result event kinds
  localparam logic [1:0] EV_DOWN = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_MOVE = 2'd2;
  localparam logic [1:0] EV_REL  = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  localparam logic [15:0] SCALE_RESET = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] x;
    logic [15:0] y;
  } slot_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_valid;
  } mem_ctl_t;

  // Round to nearest (ties up), divide by 256, saturate to 16 bits signed.
  function automatic logic [15:0] sat_round(input logic signed [33:0] p);
    logic signed [33:0] s;
    logic signed [25:0] q;
    logic [15:0] r;
    s = p + 34'sd128;
    q = s[33:8];
    if (q > 26'sd32767) begin
      r = 16'h7fff;
    end else if (q < -26'sd32768) begin
      r = 16'h8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tst_slot_mem.sv -----
`default_nettype none

module tst_slot_mem import tst_pkg::*; #(
  parameter int SLOTS = 10,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mem_ctl_t    ctl,
  input  wire logic [SW-1:0] rd_addr,
  output slot_entry_t      rd_data,
  input  wire logic [SW-1:0] wr_addr,
  input  wire slot_entry_t wr_data
);

  slot_entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  slot_entry_t rd_q;
  logic rd_v;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits stand for the all-zero reset contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_v  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[wr_addr] <= ctl.wr_valid;
      end
      if (ctl.rd_en) begin
        rd_v <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

`default_nettype wire

// ----- sv/tst_ctrl.sv -----
`default_nettype none

module tst_ctrl import tst_pkg::*; #(
  parameter int SLOTS = 10,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] contents_scale,
  input  wire logic        window_present,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [31:0] touch_id,
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [15:0] pressure,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       event_kind,
  output logic [3:0]       slot,
  output logic [15:0]      out_x,
  output logic [15:0]      out_y,
  output logic [15:0]      out_pressure,
  output logic             last,
  output mem_ctl_t         mem_ctl,
  output logic [SW-1:0]    rd_addr,
  input  wire slot_entry_t rd_data,
  output logic [SW-1:0]    wr_addr,
  output slot_entry_t      wr_data
);

  state_t state, state_next;

  logic [1:0]  op_r;
  logic [31:0] id_r;
  logic [15:0] x_r, y_r, pr_r;

  logic [CW-1:0] rd_idx;
  logic [SW-1:0] chk_idx;
  logic          chk_v;
  logic [SW-1:0] hit_slot;
  logic [15:0]   old_x, old_y;
  logic signed [33:0] prod_x, prod_y;

  logic        in_go, issue, match, scan_end, out_free, load1, load2;
  logic [31:0] target;
  logic signed [16:0] dx, dy, sc;

  assign in_go    = window_present && (touch_id != '0) && (operation != OP_NONE);
  assign target   = (op_r == OP_DOWN) ? '0 : id_r;
  assign issue    = (rd_idx < CW'(SLOTS));
  assign match    = chk_v && (rd_data.id == target);
  assign scan_end = chk_v && (chk_idx == SW'(SLOTS - 1));
  assign out_free = !out_valid || !out_stall;

  assign dx = $signed({x_r[15], x_r}) - $signed({old_x[15], old_x});
  assign dy = $signed({y_r[15], y_r}) - $signed({old_y[15], old_y});
  assign sc = $signed({1'b0, contents_scale});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_go) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          state_next = ST_UPDATE;
        end else if (scan_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_UPDATE: state_next = ST_EMIT1;
      ST_EMIT1: begin
        if (out_free) begin
          state_next = (op_r == OP_MOVE) ? ST_EMIT2 : ST_IDLE;
        end
      end
      ST_EMIT2: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    mem_ctl.rd_en    = 1'b0;
    mem_ctl.wr_en    = 1'b0;
    mem_ctl.wr_valid = (op_r != OP_UP);
    load1            = 1'b0;
    load2            = 1'b0;
    case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_SCAN:   mem_ctl.rd_en = issue;
      ST_UPDATE: mem_ctl.wr_en = 1'b1;
      ST_EMIT1:  load1 = out_free;
      ST_EMIT2:  load2 = out_free;
      default:   in_stall = 1'b1;
    endcase
  end

  assign rd_addr = rd_idx[SW-1:0];
  assign wr_addr = hit_slot;
  assign wr_data = '{id: id_r, x: x_r, y: y_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chk_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      chk_v <= (state == ST_SCAN) && issue && !match;
      if (load1 || load2) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        op_r   <= operation;
        id_r   <= touch_id;
        x_r    <= pos_x;
        y_r    <= pos_y;
        pr_r   <= pressure;
        rd_idx <= '0;
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        chk_idx <= rd_idx[SW-1:0];
        if (match) begin
          hit_slot <= chk_idx;
          old_x    <= rd_data.x;
          old_y    <= rd_data.y;
        end
      end
      ST_UPDATE: begin
        prod_x <= dx * sc;
        prod_y <= dy * sc;
      end
      default: begin
      end
    endcase

    if (load1) begin
      event_kind   <= (op_r == OP_DOWN) ? EV_DOWN :
                      (op_r == OP_UP)   ? EV_UP   : EV_MOVE;
      slot         <= 4'(hit_slot);
      out_x        <= x_r;
      out_y        <= y_r;
      out_pressure <= pr_r;
      last         <= (op_r != OP_MOVE);
    end else if (load2) begin
      event_kind   <= EV_REL;
      slot         <= 4'(hit_slot);
      out_x        <= sat_round(prod_x);
      out_y        <= sat_round(prod_y);
      out_pressure <= pr_r;
      last         <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/touch_slot_tracker_top.sv -----
// Channel  Dir  Handshake           Beat
// -------  ---  ------------------  -------------------------------------------
// in       in   in_valid/in_stall   operation, touch_id, pos_x, pos_y, pressure
// out      out  out_valid/out_stall event_kind, slot, out_x, out_y,
//                                   out_pressure, last
// cfg      in   cfg_we              cfg_index, cfg_data (no stall, no read)
//
// One item at a time: the block takes it, scans the slot memory to a hit,
// writes the slot back and then drives one result beat, or two for a move.
// Ignored items (no window, id zero, operation 3) and misses give no beat.
// Synchronous reset frees every slot via valid bits.
// An output stall holds the result register and the sequencer; in_stall is
// high whenever the sequencer is not idle.
`default_nettype none

module touch_slot_tracker_top import tst_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic signed [31:0]    touch_id,
  input  wire logic signed [15:0]    pos_x,
  input  wire logic signed [15:0]    pos_y,
  input  wire logic [15:0]           pressure,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 event_kind,
  output logic [3:0]                 slot,
  output logic signed [15:0]         out_x,
  output logic signed [15:0]         out_y,
  output logic [15:0]                out_pressure,
  output logic                       last,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0]   contents_scale;
  logic          window_present;
  mem_ctl_t      mem_ctl;
  logic [SW-1:0] rd_addr, wr_addr;
  slot_entry_t   rd_data, wr_data;
  logic [15:0]   ox, oy;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      contents_scale <= SCALE_RESET;
      window_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:  contents_scale <= cfg_data;
        CFG_WINDOW: window_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Slot table: id and last position per slot, one read and one write port.
  tst_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Sequencer: scan for a slot and, on a hit, write back, then drive one or two beats.
  tst_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .contents_scale (contents_scale),
    .window_present (window_present),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .touch_id       (touch_id),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pressure       (pressure),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .slot           (slot),
    .out_x          (ox),
    .out_y          (oy),
    .out_pressure   (out_pressure),
    .last           (last),
    .mem_ctl        (mem_ctl),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data)
  );

  assign out_x = $signed(ox);
  assign out_y = $signed(oy);

endmodule

`default_nettype wire

// ----- sv/tst_checker.sv -----
`default_nettype none

module tst_checker import tst_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  event_kind,
  input wire logic [3:0]  slot,
  input wire logic [15:0] out_x,
  input wire logic [15:0] out_y,
  input wire logic [15:0] out_pressure,
  input wire logic        last
);

  // Stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(slot) &&
      $stable(out_x) && $stable(out_y) && $stable(out_pressure) && $stable(last))
    else $error("stalled output beat changed");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Only a finger move is followed by another beat, and the block stays busy.
  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> event_kind == EV_MOVE && in_stall)
    else $error("non-final beat is not a busy finger move");

  // Every other kind closes its item.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_MOVE |-> last)
    else $error("final beat not marked last");

endmodule

bind touch_slot_tracker_top tst_checker u_tst_checker (.*);

`default_nettype wire

// ----- verif/touch_slot_checker.sv -----
`timescale 1ns / 1ps

module touch_slot_checker import tst_pkg::*; #(
  parameter int SLOTS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            operation,
  input  logic [31:0]           touch_id,
  input  logic [15:0]           pos_x,
  input  logic [15:0]           pos_y,
  input  logic [15:0]           pressure,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            event_kind,
  input  logic [3:0]            slot,
  input  logic [15:0]           out_x,
  input  logic [15:0]           out_y,
  input  logic [15:0]           out_pressure,
  input  logic                  last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    events_due
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pr;
    logic        fin;
  } touch_event_t;

  // Shadow copy of the slot table and the registers.
  logic [31:0] held_id [SLOTS];
  logic [15:0] held_x  [SLOTS];
  logic [15:0] held_y  [SLOTS];
  logic [15:0] scale_q;
  logic        window_on;

  touch_event_t event_q[$];
  int           beats_seen;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  function automatic int lowest_slot(input logic [31:0] key);
    for (int i = 0; i < SLOTS; i++) begin
      if (held_id[i] == key) return i;
    end
    return -1;
  endfunction

  // Q8.8 scaling of a position delta: round half up, then saturate.
  function automatic logic [15:0] scaled_delta(input logic [15:0] now,
                                               input logic [15:0] prev);
    longint d;
    longint p;
    longint q;
    d = longint'($signed(now)) - longint'($signed(prev));
    p = d * longint'(scale_q) + 128;
    q = p >>> 8;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic touch_event_t beat_of(input logic [1:0] kind, input int s,
                                           input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] pr, input logic fin);
    touch_event_t ev;
    ev.kind = kind;
    ev.slot = s[3:0];
    ev.x    = x;
    ev.y    = y;
    ev.pr   = pr;
    ev.fin  = fin;
    return ev;
  endfunction

  task automatic track_touch(input logic [1:0] op, input logic [31:0] id,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] pr);
    int s;
    if (!window_on || id == 32'd0 || op == OP_NONE) return;
    if (op == OP_DOWN) begin
      s = lowest_slot(32'd0);
      if (s < 0) return;
      held_id[s] = id;
      held_x[s]  = x;
      held_y[s]  = y;
      event_q.push_back(beat_of(EV_DOWN, s, x, y, pr, 1'b1));
      return;
    end
    s = lowest_slot(id);
    if (s < 0) return;
    if (op == OP_UP) begin
      held_x[s]  = x;
      held_y[s]  = y;
      held_id[s] = 32'd0;
      event_q.push_back(beat_of(EV_UP, s, x, y, pr, 1'b1));
      return;
    end
    event_q.push_back(beat_of(EV_MOVE, s, x, y, pr, 1'b0));
    event_q.push_back(beat_of(EV_REL, s, scaled_delta(x, held_x[s]),
                              scaled_delta(y, held_y[s]), pr, 1'b1));
    held_x[s] = x;
    held_y[s] = y;
  endtask

  initial begin
    fail_count = 0;
    events_due = 0;
    beats_seen = 0;
  end

  always @(posedge clk) begin
    touch_event_t want;
    touch_event_t got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        held_id[i] = 32'd0;
        held_x[i]  = 16'd0;
        held_y[i]  = 16'd0;
      end
      scale_q   = SCALE_RESET;
      window_on = 1'b1;
      event_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE:  scale_q   = cfg_data;
          CFG_WINDOW: window_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_touch(operation, touch_id, pos_x, pos_y, pressure);
      if (out_valid && !out_stall) begin
        got = beat_of(event_kind, int'(slot), out_x, out_y, out_pressure, last);
        if (event_q.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
        end else begin
          want = event_q.pop_front();
          if (got.kind !== want.kind || got.slot !== want.slot || got.x !== want.x ||
              got.y !== want.y || got.pr !== want.pr || got.fin !== want.fin)
            report_mismatch($sformatf(
              "beat %0d got k%0d s%0d x%h y%h p%h l%b, want k%0d s%0d x%h y%h p%h l%b",
              beats_seen, got.kind, got.slot, got.x, got.y, got.pr, got.fin,
              want.kind, want.slot, want.x, want.y, want.pr, want.fin));
        end
        beats_seen++;
      end
    end
    events_due = event_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tst_pkg::*;

  localparam int SLOTS = 10;
  // A miss scans every slot before going idle; give it room before config writes.
  localparam int SETTLE_CYCLES = SLOTS + 12;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [1:0]            operation    = OP_NONE;
  logic [31:0]           touch_id     = 32'd0;
  logic [15:0]           pos_x        = 16'd0;
  logic [15:0]           pos_y        = 16'd0;
  logic [15:0]           pressure     = 16'd0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [1:0]            event_kind;
  logic [3:0]            slot;
  logic [15:0]           out_x;
  logic [15:0]           out_y;
  logic [15:0]           out_pressure;
  logic                  last;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data     = 16'd0;

  int fail_count;
  int events_due;

  // Idle rates in percent, changed per phase; hold_req asks the receiver
  // for one long hold-off.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  // Small pool of ids so moves and releases mostly hit occupied slots.
  logic [31:0] id_pool [16];

  touch_slot_tracker_top #(.SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .touch_id(touch_id), .pos_x(pos_x), .pos_y(pos_y),
    .pressure(pressure),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .slot(slot), .out_x(out_x), .out_y(out_y),
    .out_pressure(out_pressure), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  touch_slot_checker #(.SLOTS(SLOTS)) events_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .touch_id(touch_id), .pos_x(pos_x), .pos_y(pos_y),
    .pressure(pressure),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_kind(event_kind), .slot(slot), .out_x(out_x), .out_y(out_y),
    .out_pressure(out_pressure), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .events_due(events_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: stall at the phase rate, or hold off for a counted stretch
  // when asked so the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and wait for the
  // handshake. Valid stays high afterward so back-to-back beats never
  // drop it within a step.
  task automatic offer_touch(input logic [1:0] op, input logic [31:0] id,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    touch_id  <= id;
    pos_x     <= x;
    pos_y     <= y;
    pressure  <= pr;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, drain every expected beat, then let a trailing miss scan finish.
  task automatic drain_events;
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] scale, input logic win);
    drain_events();
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_WINDOW, {15'd0, win});
  endtask

  function automatic logic [15:0] pick_scale;
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd128;
      3: return 16'd256;
      4: return 16'hffff;
      5: return 16'd384;
      default: return 16'($urandom);
    endcase
  endfunction

  // Half near-origin positions so deltas stay in range, half full-range.
  function automatic logic [15:0] pick_pos;
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($urandom_range(256)) - 16'd128;
  endfunction

  task automatic random_touch;
    logic [1:0]  op;
    logic [31:0] id;
    int          r;
    r = $urandom_range(99);
    op = (r < 45) ? OP_MOVE : (r < 72) ? OP_DOWN : (r < 96) ? OP_UP : OP_NONE;
    r = $urandom_range(99);
    if (r < 3) id = 32'd0;
    else if (r < 8) id = $urandom;
    else id = id_pool[$urandom_range(15)];
    // Refresh the pool now and then so every id bit gets exercised.
    if ($urandom_range(49) == 0) id_pool[$urandom_range(15)] = $urandom;
    offer_touch(op, id, pick_pos(), pick_pos(), 16'($urandom));
  endtask

  // One idling phase in four chunks, each under a fresh scale.
  task automatic run_phase(input int idle, input int stall, input int n_items,
                           input bit hold, input bit dark_burst);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int c = 0; c < 4; c++) begin
      set_config(pick_scale(), 1'b1);
      if (hold && c == 1) hold_req = 1'b1;
      repeat (n_items / 4) random_touch();
    end
    if (dark_burst) begin
      // No window: everything is swallowed.
      set_config(pick_scale(), 1'b0);
      repeat (8) random_touch();
    end
  endtask

  initial begin
    id_pool[0] = 32'd1;
    id_pool[1] = 32'hffff_ffff;
    id_pool[2] = 32'h8000_0000;
    id_pool[3] = 32'h7fff_ffff;
    for (int i = 4; i < 16; i++) id_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every operation and each corner of the table.
    offer_touch(OP_DOWN, 32'd1, 16'h7fff, 16'h8000, 16'hffff);
    offer_touch(OP_MOVE, 32'd1, 16'h8000, 16'h7fff, 16'h0000);  // saturates both ways
    offer_touch(OP_DOWN, 32'hffff_ffff, 16'd0, 16'd0, 16'h1234);
    offer_touch(OP_DOWN, 32'h8000_0000, 16'd0, 16'd0, 16'h8000);
    offer_touch(OP_DOWN, 32'h7fff_ffff, 16'd0, 16'd0, 16'h0001);
    offer_touch(OP_DOWN, 32'd0, 16'd5, 16'd5, 16'd5);           // reserved id
    offer_touch(OP_NONE, 32'd1, 16'd5, 16'd5, 16'd5);           // unknown operation
    offer_touch(OP_MOVE, 32'd12345, 16'd5, 16'd5, 16'd5);       // unknown id
    offer_touch(OP_UP, 32'd12345, 16'd5, 16'd5, 16'd5);
    offer_touch(OP_DOWN, 32'd1, 16'h0010, 16'hfff0, 16'd7);     // duplicate press
    offer_touch(OP_UP, 32'd1, 16'd3, 16'd4, 16'd9);             // lowest match goes
    offer_touch(OP_MOVE, 32'd1, 16'h0020, 16'hffe0, 16'd11);
    for (int i = 0; i < 6; i++)
      offer_touch(OP_DOWN, 32'd100 + i, 16'(i), 16'(-i), 16'(i));
    offer_touch(OP_DOWN, 32'd106, 16'd1, 16'd1, 16'd1);         // table full
    offer_touch(OP_UP, 32'h7fff_ffff, 16'h7fff, 16'h7fff, 16'hffff);

    // Half-way rounding ties.
    set_config(16'd128, 1'b1);
    offer_touch(OP_MOVE, 32'h8000_0000, 16'd1, 16'hffff, 16'd2);
    set_config(16'hffff, 1'b1);
    offer_touch(OP_MOVE, 32'hffff_ffff, 16'd1, 16'hffff, 16'd3);
    set_config(16'd0, 1'b0);
    offer_touch(OP_DOWN, 32'd200, 16'd1, 16'd1, 16'd1);         // no window
    set_config(SCALE_RESET, 1'b1);
    offer_touch(OP_UP, 32'h8000_0000, 16'h8000, 16'h8000, 16'd0);

    // Random phases: no idling (with the long hold-off), sender idle,
    // receiver stalling, both.
    run_phase(0, 0, 200, 1'b1, 1'b0);
    run_phase(71, 0, 200, 1'b0, 1'b1);
    run_phase(0, 71, 200, 1'b0, 1'b0);
    run_phase(17, 17, 200, 1'b0, 1'b0);

    drain_events();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tst_pkg.sv
sv/tst_slot_mem.sv
sv/tst_ctrl.sv
sv/touch_slot_tracker_top.sv
sv/tst_checker.sv
verif/touch_slot_checker.sv
verif/tb_top.sv
